// ----- design/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [TIMER_W-1:0] LAST_TIMER = TIMER_W'(NUM_TIMERS - 1);

	localparam logic [31:0] DEFAULT_PERIOD_RESET = 32'd1000;
	localparam logic [31:0] STAGE_MAX            = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_START      = 2'd1,
		OP_STOP       = 2'd2,
		OP_SET_PERIOD = 2'd3
	} op_t;

	// per-timer context, always written as a whole
	typedef struct packed {
		logic [31:0] remaining;
		logic [30:0] limit;
		logic [31:0] stage;
	} ctx_t;

	typedef struct packed {
		logic               load;      // latch the accepted request
		logic               rd_en;     // read timer memories
		logic               rd_input;  // read address from timer_index
		logic [TIMER_W-1:0] rd_idx;    // scan read address
		logic               ev_valid;  // evaluation stage holds a timer
		logic [TIMER_W-1:0] ev_idx;    // timer in the evaluation stage
		logic               apply;     // execute start / stop / set period
		logic               flush;     // release the held event as last
	} cmd_t;

	typedef struct packed {
		logic in_tick;     // offered request is a tick
		logic hold;        // evaluation stage cannot retire this cycle
		logic flush_done;  // nothing left to release
	} sts_t;

endpackage

`default_nettype wire

// ----- design/periodic_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers driven by tick / start / stop / set period requests.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid, in_stall   | operation, timer_index, period_ticks,
//            |                      | count_limit, start_stage
//   out      | out_valid, out_stall | fired_timer, fired_stage, last
//   cfg      | cfg_valid, cfg_ready | default_period
//
// Start, stop and set period pass through the apply state. A tick scans all
// timers, one timer memory read per cycle unless the evaluation stage holds,
// evaluating each timer while the next is read, then releases the final event.
// Each event is held back one step so that last can be set on the final one;
// a stalled output stops the scan until the output register frees up.
// Reset clears all run flags and restores the default period; no
// memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [4:0]  timer_index,
	input  wire logic [31:0] period_ticks,
	input  wire logic [30:0] count_limit,
	input  wire logic [30:0] start_stage,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] default_period,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       fired_timer,
	output logic [31:0]      fired_stage,
	output logic             last
);

	ptb_pkg::cmd_t cmd;
	ptb_pkg::sts_t sts;

	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.timer_index    (timer_index),
		.period_ticks   (period_ticks),
		.count_limit    (count_limit),
		.start_stage    (start_stage),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.default_period (default_period),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.fired_timer    (fired_timer),
		.fired_stage    (fired_stage),
		.last           (last)
	);

endmodule

`default_nettype wire

// ----- design/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: accepts requests, runs the per-tick scan over all timers and
// the final event release.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ptb_pkg::sts_t sts,
	output ptb_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t                        state_q;
	logic [ptb_pkg::TIMER_W-1:0]   rd_idx_q;
	logic [ptb_pkg::TIMER_W-1:0]   ev_idx_q;
	logic                          ev_valid_q;
	logic                          accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.rd_en    = accept || ((state_q == ST_SCAN) && !sts.hold);
		cmd.rd_input = (state_q == ST_IDLE);
		cmd.rd_idx   = rd_idx_q;
		cmd.ev_valid = ev_valid_q;
		cmd.ev_idx   = ev_idx_q;
		cmd.apply    = (state_q == ST_APPLY);
		cmd.flush    = (state_q == ST_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			ev_idx_q   <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q   <= '0;
						ev_valid_q <= 1'b0;
						state_q    <= sts.in_tick ? ST_SCAN : ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// read of timer i overlaps evaluation of timer i-1
					if (!sts.hold) begin
						ev_valid_q <= 1'b1;
						ev_idx_q   <= rd_idx_q;
						if (rd_idx_q == ptb_pkg::LAST_TIMER) begin
							state_q <= ST_DRAIN;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!sts.hold) begin
						ev_valid_q <= 1'b0;
						state_q    <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (sts.flush_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/ptb_datapath.sv -----
// ----------------------------------------------------------------------------
// ptb_datapath
// Timer state memories, run and period-valid flags, expiry evaluation and
// the event output path (one held event plus the output register).
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ptb_pkg::cmd_t cmd,
	output ptb_pkg::sts_t      sts,
	input  wire logic [1:0]    operation,
	input  wire logic [4:0]    timer_index,
	input  wire logic [31:0]   period_ticks,
	input  wire logic [30:0]   count_limit,
	input  wire logic [30:0]   start_stage,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [31:0]   default_period,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [4:0]         fired_timer,
	output logic [31:0]        fired_stage,
	output logic               last
);

	localparam int TW = ptb_pkg::TIMER_W;
	localparam int NT = ptb_pkg::NUM_TIMERS;

	// memories
	logic [31:0]       period_mem [NT];
	ptb_pkg::ctx_t     ctx_mem    [NT];

	logic [31:0]       per_s1;
	logic              pval_s1;
	ptb_pkg::ctx_t     ctx_s1;

	logic [NT-1:0]     running_q;
	logic [NT-1:0]     pvalid_q;    // period entry overrides default
	logic [31:0]       default_q;

	// latched request
	logic [1:0]        op_q;
	logic [4:0]        idx_q;
	logic [31:0]       per_q;
	logic [30:0]       cnt_q;
	logic [30:0]       stg_q;

	// output path
	logic              out_valid_q;
	logic              pend_valid_q;
	logic [TW-1:0]     pend_idx_q;
	logic [31:0]       pend_stage_q;
	logic [4:0]        fired_timer_q;
	logic [31:0]       fired_stage_q;
	logic              last_q;

	logic [TW-1:0]     rd_addr;
	logic [TW-1:0]     ap_addr;
	logic              in_range;
	logic              cfg_wr;
	logic [31:0]       eff_period;
	logic [31:0]       reload;
	logic [31:0]       start_base;
	logic              run;
	logic              expire;
	logic              limit_hit;
	logic              fire;
	logic              ev_go;
	logic              out_free;
	logic              ap_start;
	logic              ap_stop;
	logic              ap_setp;
	logic              per_we;
	logic [31:0]       per_wd;
	logic              ctx_we;
	logic [TW-1:0]     ctx_wa;
	ptb_pkg::ctx_t     ctx_wd;
	logic [31:0]       stage_inc;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	assign rd_addr  = cmd.rd_input ? TW'(timer_index) : cmd.rd_idx;
	assign ap_addr  = TW'(idx_q);
	assign in_range = (32'(idx_q) < 32'(NT));

	assign ap_start = cmd.apply && in_range && (op_q == ptb_pkg::OP_START);
	assign ap_stop  = cmd.apply && in_range && (op_q == ptb_pkg::OP_STOP);
	assign ap_setp  = cmd.apply && in_range && (op_q == ptb_pkg::OP_SET_PERIOD);

	assign eff_period = pval_s1 ? per_s1 : default_q;
	assign reload     = (eff_period == 32'd0) ? 32'd1 : eff_period;
	assign start_base = (per_q != 32'd0) ? per_q : eff_period;

	// expiry evaluation of the timer in the evaluation stage
	assign run       = running_q[cmd.ev_idx];
	assign expire    = run && (ctx_s1.remaining <= 32'd1);
	assign limit_hit = (ctx_s1.limit != 31'd0) && (ctx_s1.stage >= {1'b0, ctx_s1.limit});
	assign fire      = expire && !limit_hit;
	assign stage_inc = (ctx_s1.stage == ptb_pkg::STAGE_MAX) ? ctx_s1.stage
	                                                         : ctx_s1.stage + 32'd1;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts            = '0;
		sts.in_tick    = (operation == ptb_pkg::OP_TICK);
		// a new event needs the held one moved out first
		sts.hold       = cmd.ev_valid && fire && pend_valid_q && !out_free;
		sts.flush_done = !pend_valid_q || out_free;
	end

	assign ev_go = cmd.ev_valid && !sts.hold;

	always_comb begin
		per_we = ap_setp || (ap_start && (per_q != 32'd0));
		per_wd = per_q;
		ctx_we = 1'b0;
		ctx_wa = cmd.ev_idx;
		ctx_wd = ctx_s1;
		if (ap_start) begin
			ctx_we           = 1'b1;
			ctx_wa           = ap_addr;
			ctx_wd.remaining = (start_base == 32'd0) ? 32'd1 : start_base;
			ctx_wd.limit     = cnt_q;
			ctx_wd.stage     = {1'b0, stg_q};
		end else if (ev_go && run) begin
			ctx_we = 1'b1;
			if (!expire) begin
				ctx_wd.remaining = ctx_s1.remaining - 32'd1;
			end else begin
				ctx_wd.remaining = reload;
				if (fire) begin
					ctx_wd.stage = stage_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (per_we) begin
			period_mem[ap_addr] <= per_wd;
		end
		if (ctx_we) begin
			ctx_mem[ctx_wa] <= ctx_wd;
		end
		if (cmd.rd_en) begin
			per_s1  <= period_mem[rd_addr];
			pval_s1 <= pvalid_q[rd_addr];
			ctx_s1  <= ctx_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			idx_q <= timer_index;
			per_q <= period_ticks;
			cnt_q <= count_limit;
			stg_q <= start_stage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			pvalid_q  <= '0;
			default_q <= ptb_pkg::DEFAULT_PERIOD_RESET;
		end else begin
			if (cfg_wr) begin
				// every timer falls back to the new default period
				default_q <= default_period;
				pvalid_q  <= '0;
			end else if (per_we) begin
				pvalid_q[ap_addr] <= 1'b1;
			end
			if (ap_start) begin
				running_q[ap_addr] <= 1'b1;
			end else if (ap_stop) begin
				running_q[ap_addr] <= 1'b0;
			end else if (ev_go && expire && limit_hit) begin
				running_q[cmd.ev_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ev_go && fire) begin
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
				pend_valid_q <= 1'b1;
			end else if (cmd.flush && pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_go && fire) begin
			if (pend_valid_q) begin
				fired_timer_q <= 5'(pend_idx_q);
				fired_stage_q <= pend_stage_q;
				last_q        <= 1'b0;
			end
			pend_idx_q   <= cmd.ev_idx;
			pend_stage_q <= ctx_s1.stage;
		end else if (cmd.flush && pend_valid_q && out_free) begin
			fired_timer_q <= 5'(pend_idx_q);
			fired_stage_q <= pend_stage_q;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign fired_timer = fired_timer_q;
	assign fired_stage = fired_stage_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- sim/tb_periodic_timer_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_timer_bank
// Self-checking bench for the periodic timer bank. A directed table covers
// period zero, restarts, silent stops at the count limit and field extremes.
// Random requests then run under several default periods, with random idling
// on both channels, a long output hold-off and a stretch with no idling.
// Every firing event is checked field by field against a built-in model or a typed row.
// ----------------------------------------------------------------------------

module tb_periodic_timer_bank;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE       = 40;    // tick scan plus output release
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 82;

	typedef struct packed {
		logic [4:0]  timer;
		logic [31:0] stage;
		logic        last_flag;
	} fire_t;

	typedef struct {
		ptb_pkg::op_t op;
		logic [4:0]  idx;
		logic [31:0] per;
		logic [30:0] cnt;
		logic [30:0] stg;
		int          typed_n;   // -1: use model, 0: none, 1: one event below
		logic [4:0]  t_timer;
		logic [31:0] t_stage;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = ptb_pkg::OP_TICK;
	logic [4:0]  timer_index = '0;
	logic [31:0] period_ticks = '0;
	logic [30:0] count_limit = '0;
	logic [30:0] start_stage = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] default_period = ptb_pkg::DEFAULT_PERIOD_RESET;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  fired_timer;
	logic [31:0] fired_stage;
	logic        last;

	periodic_timer_bank dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.timer_index    (timer_index),
		.period_ticks   (period_ticks),
		.count_limit    (count_limit),
		.start_stage    (start_stage),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.default_period (default_period),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.fired_timer    (fired_timer),
		.fired_stage    (fired_stage),
		.last           (last)
	);

	always #4 clk = ~clk;

	// timer bank model
	logic        run_flag     [ptb_pkg::NUM_TIMERS];
	logic [31:0] reload_ticks [ptb_pkg::NUM_TIMERS];
	logic [31:0] ticks_left   [ptb_pkg::NUM_TIMERS];
	logic [30:0] stop_stage   [ptb_pkg::NUM_TIMERS];
	logic [31:0] next_stage   [ptb_pkg::NUM_TIMERS];

	fire_t pending_fires [$];
	fire_t step_events [$];
	row_t  dir_rows [$];

	int    error_count = 0;
	int    cycle_count = 0;
	int    rand_sent = 0;
	bit    steady = 1'b0;
	int    hold_asks = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	fire_t seen_want;

	initial begin
		for (int i = 0; i < ptb_pkg::NUM_TIMERS; i++) begin
			run_flag[i]     = 1'b0;
			reload_ticks[i] = ptb_pkg::DEFAULT_PERIOD_RESET;
			ticks_left[i]   = '0;
			stop_stage[i]   = '0;
			next_stage[i]   = '0;
		end
	end

	function automatic logic [31:0] eff_period(input logic [31:0] p);
		return (p == 32'd0) ? 32'd1 : p;
	endfunction

	task automatic flag_error(input string msg);
		if (error_count < 100)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// applies one request to the model; firing events land in step_events
	task automatic advance_timers(input ptb_pkg::op_t op, input logic [4:0] idx,
			input logic [31:0] per, input logic [30:0] cnt, input logic [30:0] stg);
		fire_t ev;
		step_events.delete();
		case (op)
			ptb_pkg::OP_START: begin
				if (per != 32'd0)
					reload_ticks[idx] = per;
				ticks_left[idx] = eff_period(reload_ticks[idx]);
				stop_stage[idx] = cnt;
				next_stage[idx] = {1'b0, stg};
				run_flag[idx]   = 1'b1;
			end
			ptb_pkg::OP_STOP: run_flag[idx] = 1'b0;
			ptb_pkg::OP_SET_PERIOD: reload_ticks[idx] = per;
			default: begin
				for (int i = 0; i < ptb_pkg::NUM_TIMERS; i++) begin
					if (run_flag[i]) begin
						if (ticks_left[i] > 32'd1) begin
							ticks_left[i] = ticks_left[i] - 32'd1;
						end else begin
							ticks_left[i] = eff_period(reload_ticks[i]);
							if (stop_stage[i] != '0 &&
									next_stage[i] >= {1'b0, stop_stage[i]}) begin
								run_flag[i] = 1'b0;
							end else begin
								ev.timer     = 5'(i);
								ev.stage     = next_stage[i];
								ev.last_flag = 1'b0;
								step_events.push_back(ev);
								if (next_stage[i] != ptb_pkg::STAGE_MAX)
									next_stage[i] = next_stage[i] + 32'd1;
							end
						end
					end
				end
				if (step_events.size() != 0) begin
					ev = step_events.pop_back();
					ev.last_flag = 1'b1;
					step_events.push_back(ev);
				end
			end
		endcase
	endtask

	task automatic issue_request(input ptb_pkg::op_t op, input logic [4:0] idx,
			input logic [31:0] per, input logic [30:0] cnt, input logic [30:0] stg,
			input int typed_n, input logic [4:0] t_timer, input logic [31:0] t_stage);
		fire_t ev;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		timer_index  <= idx;
		period_ticks <= per;
		count_limit  <= cnt;
		start_stage  <= stg;
		do @(posedge clk); while (in_stall);
		advance_timers(op, idx, per, cnt, stg);
		if (typed_n < 0) begin
			foreach (step_events[k])
				pending_fires.push_back(step_events[k]);
		end else if (typed_n == 1) begin
			ev.timer     = t_timer;
			ev.stage     = t_stage;
			ev.last_flag = 1'b1;
			pending_fires.push_back(ev);
		end
	endtask

	// lower valid, wait for every expected event, then let a tick scan finish
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fires.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_default(input logic [31:0] value);
		@(negedge clk);
		cfg_valid      <= 1'b1;
		default_period <= value;
		do @(posedge clk); while (!cfg_ready);
		for (int i = 0; i < ptb_pkg::NUM_TIMERS; i++)
			reload_ticks[i] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 32'd0;
		if (r < 85)
			return 32'($urandom_range(6, 1));
		return 32'($urandom());
	endfunction

	task automatic send_random_item();
		int           r;
		ptb_pkg::op_t op;
		logic [4:0]   idx;
		logic [31:0]  per;
		logic [30:0]  cnt;
		logic [30:0]  stg;
		r   = $urandom_range(99);
		op  = (r < 52) ? ptb_pkg::OP_TICK : (r < 72) ? ptb_pkg::OP_START :
		      (r < 82) ? ptb_pkg::OP_STOP : ptb_pkg::OP_SET_PERIOD;
		idx = 5'($urandom_range(31));
		per = pick_period();
		stg = ($urandom_range(99) < 80) ? 31'($urandom_range(10)) : 31'($urandom());
		r   = $urandom_range(99);
		if (r < 45)
			cnt = '0;
		else if (r < 85)
			cnt = stg + 31'($urandom_range(6));
		else
			cnt = 31'($urandom());
		issue_request(op, idx, per, cnt, stg, -1, '0, '0);
	endtask

	task automatic add_row(input ptb_pkg::op_t op, input logic [4:0] idx,
			input logic [31:0] per, input logic [30:0] cnt, input logic [30:0] stg,
			input int typed_n, input logic [4:0] t_timer, input logic [31:0] t_stage);
		row_t row;
		row.op      = op;
		row.idx     = idx;
		row.per     = per;
		row.cnt     = cnt;
		row.stg     = stg;
		row.typed_n = typed_n;
		row.t_timer = t_timer;
		row.t_stage = t_stage;
		dir_rows.push_back(row);
	endtask

	// output side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 38);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fires.size() == 0) begin
				flag_error($sformatf("unexpected event timer %0d stage %0d last %0b",
					fired_timer, fired_stage, last));
			end else begin
				seen_want = pending_fires.pop_front();
				if (fired_timer !== seen_want.timer)
					flag_error($sformatf("fired_timer %0d, want %0d", fired_timer, seen_want.timer));
				if (fired_stage !== seen_want.stage)
					flag_error($sformatf("fired_stage %0d, want %0d (timer %0d)",
						fired_stage, seen_want.stage, seen_want.timer));
				if (last !== seen_want.last_flag)
					flag_error($sformatf("last %0b, want %0b (timer %0d)",
						last, seen_want.last_flag, seen_want.timer));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout, %0d events outstanding", pending_fires.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] settings [5];
		settings[0] = 32'd1;
		settings[1] = 32'hFFFF_FFFF;
		settings[2] = 32'd3;
		settings[3] = 32'd2;
		settings[4] = 32'd1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default period is 1000 here, so only explicitly set periods fire
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,  0, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START,      5'd0,  32'd1, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,  1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,  1, 5'd0, 32'd1);
		add_row(ptb_pkg::OP_SET_PERIOD, 5'd31, 32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START,      5'd31, 32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START,      5'd5,  32'd2, 31'd3, 31'd1, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START, 5'd10, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			-1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START,      5'd20, 32'd3, 31'd5, 31'd5,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_SET_PERIOD, 5'd31, 32'd3, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_START,      5'd31, 32'd0, 31'd0, 31'd100, -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd0,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd0,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd31, 32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd5,  32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd10, 32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_STOP,       5'd20, 32'd0, 31'd0, 31'd0,   -1, 5'd0, 32'd0);
		add_row(ptb_pkg::OP_TICK,       5'd0,  32'd0, 31'd0, 31'd0,    0, 5'd0, 32'd0);

		foreach (dir_rows[k])
			issue_request(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].per, dir_rows[k].cnt,
				dir_rows[k].stg, dir_rows[k].typed_n, dir_rows[k].t_timer, dir_rows[k].t_stage);

		for (int ph = 0; ph < 5; ph++) begin
			drain_and_settle();
			write_default(settings[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_random_item();
				rand_sent++;
				steady = (rand_sent >= 250 && rand_sent < 330);
				// long output hold-off while requests keep coming
				if (rand_sent == 40)
					hold_asks++;
			end
		end

		drain_and_settle();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
